FILE: design/mlpfs_pkg.sv
package mlpfs_pkg;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = 2;

  typedef enum logic [1:0] {
    CMD_WEIGHT,
    CMD_BIAS,
    CMD_EVAL
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } eng_state_t;

  typedef enum logic [1:0] {
    LYR_ONE,
    LYR_TWO,
    LYR_THREE
  } layer_t;

  // One classified word as it waits between front and engine.
  typedef struct packed {
    cmd_t        cmd;
    logic [7:0]  addr;
    logic [15:0] value;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] x2;
  } queue_word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

FILE: design/mlpfs_front.sv
module mlpfs_front import mlpfs_pkg::*; #(
  parameter int WEIGHT_TOTAL = 115,
  parameter int BIAS_TOTAL   = 25
) (
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               command,
  input  logic [7:0]         param_index,
  input  logic signed [15:0] param_value,
  input  logic signed [15:0] input_first,
  input  logic signed [15:0] input_second,
  input  logic signed [15:0] input_third,
  input  queue_status_t      q_stat,
  output logic               push,
  output queue_word_t        word
);

  logic        accept;
  logic        is_weight;
  logic        is_bias;
  logic [31:0] index_wide;

  assign item_stall = q_stat.full;
  assign accept     = item_valid && !item_stall;
  assign index_wide = 32'(param_index);
  assign is_weight  = index_wide < 32'(WEIGHT_TOTAL);
  assign is_bias    = !is_weight && (index_wide < 32'(WEIGHT_TOTAL + BIAS_TOTAL));

  always_comb begin
    word.value = param_value;
    word.x0    = input_first;
    word.x1    = input_second;
    word.x2    = input_third;
    word.addr  = param_index;
    word.cmd   = CMD_EVAL;
    push       = accept;
    if (!command) begin
      if (is_weight) begin
        word.cmd = CMD_WEIGHT;
      end else if (is_bias) begin
        word.cmd  = CMD_BIAS;
        word.addr = 8'(index_wide - 32'(WEIGHT_TOTAL));
      end else begin
        // drop loads past the end of the bias store
        push = 1'b0;
      end
    end
  end

endmodule

FILE: design/mlpfs_queue.sv
module mlpfs_queue import mlpfs_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  queue_word_t   word,
  input  logic          pop,
  output queue_word_t   head,
  output queue_status_t q_stat
);

  queue_word_t            slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr;
  logic [QUEUE_PTR_W-1:0] rd_ptr;
  logic [QUEUE_PTR_W:0]   count;
  logic                   do_push;
  logic                   do_pop;

  assign q_stat.full  = count == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH);
  assign q_stat.empty = count == '0;
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: design/mlpfs_engine.sv
module mlpfs_engine import mlpfs_pkg::*; #(
  parameter int INPUT_COUNT         = 3,
  parameter int HIDDEN1_COUNT       = 5,
  parameter int HIDDEN2_COUNT       = 5,
  parameter int OUTPUT_COUNT        = 15,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst,
  input  queue_word_t   head,
  input  queue_status_t q_stat,
  output logic          pop,
  output logic          result_valid,
  input  logic          result_stall,
  output logic [3:0]    output_index,
  output logic [15:0]   output_score,
  output logic          last
);

  localparam int WEIGHT_TOTAL = HIDDEN1_COUNT * INPUT_COUNT + HIDDEN2_COUNT * HIDDEN1_COUNT
                                + OUTPUT_COUNT * HIDDEN2_COUNT;
  localparam int BIAS_TOTAL   = HIDDEN1_COUNT + HIDDEN2_COUNT + OUTPUT_COUNT;
  localparam int ACT_TOTAL    = HIDDEN1_COUNT + HIDDEN2_COUNT;
  localparam int MAX_FANIN    = (INPUT_COUNT > HIDDEN1_COUNT)
                                ? ((INPUT_COUNT > HIDDEN2_COUNT) ? INPUT_COUNT : HIDDEN2_COUNT)
                                : ((HIDDEN1_COUNT > HIDDEN2_COUNT) ? HIDDEN1_COUNT
                                                                   : HIDDEN2_COUNT);
  localparam int MAX_FANOUT   = (HIDDEN1_COUNT > HIDDEN2_COUNT)
                                ? ((HIDDEN1_COUNT > OUTPUT_COUNT) ? HIDDEN1_COUNT : OUTPUT_COUNT)
                                : ((HIDDEN2_COUNT > OUTPUT_COUNT) ? HIDDEN2_COUNT : OUTPUT_COUNT);
  localparam int WAW   = $clog2(WEIGHT_TOTAL);
  localparam int BAW   = $clog2(BIAS_TOTAL);
  localparam int AW    = $clog2(ACT_TOTAL);
  localparam int KW    = (MAX_FANIN > 1) ? $clog2(MAX_FANIN) : 1;
  localparam int NW    = (MAX_FANOUT > 1) ? $clog2(MAX_FANOUT) : 1;
  localparam int XW    = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
  localparam int XN    = 1 << XW;
  localparam int TW    = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int DW    = $clog2(SIGMOID_TABLE_DEPTH + 1);
  localparam int ACC_W = 34 + $clog2(MAX_FANIN + 1);

  localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_LO = -ACC_W'(32768);

  typedef struct packed {
    layer_t          layer;
    logic            first;
    logic            lastk;
    logic [AW-1:0]   dest;
    logic [3:0]      oidx;
    logic            olast;
  } tag_t;

  // Long division by shift and subtract, used only to build the sigmoid table.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[62:0], num[b]};
      if (rem >= den) begin
        rem    = rem - den;
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Sigmoid at the centre of bucket idx, Q0.16: exp(-|c|) from a Taylor
  // series of exp(-|c|/16) squared four times.
  function automatic logic [15:0] sig_entry(input int idx);
    longint      n;
    logic [63:0] mag;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] e;
    logic [63:0] den;
    logic [63:0] r;
    n    = longint'(8 * (2 * idx + 1)) - longint'(8 * SIGMOID_TABLE_DEPTH);
    mag  = (n < 0) ? 64'(-n) : 64'(n);
    t    = udiv64(mag << 31, 64'(SIGMOID_TABLE_DEPTH));
    u    = t >> 4;
    term = 64'd1 << 31;
    pos  = term;
    neg  = '0;
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * u) >> 31, 64'(k));
      if (k[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    e = pos - neg;
    for (int s = 0; s < 4; s++) begin
      e = (e * e) >> 31;
    end
    den = (64'd1 << 31) + e;
    if (n >= 0) begin
      r = udiv64((64'd1 << 47) + (den >> 1), den);
    end else begin
      r = udiv64((e << 16) + (den >> 1), den);
    end
    return (r > 64'd65535) ? 16'hFFFF : r[15:0];
  endfunction

  logic [15:0] sig_rom [SIGMOID_TABLE_DEPTH];

  for (genvar g = 0; g < SIGMOID_TABLE_DEPTH; g++) begin : g_sig
    localparam logic [15:0] SIG_VAL = sig_entry(g);
    assign sig_rom[g] = SIG_VAL;
  end

  logic signed [15:0] wmem [WEIGHT_TOTAL];
  logic signed [15:0] bmem [BIAS_TOTAL];
  logic [15:0]        act  [ACT_TOTAL];

  logic signed [15:0] x_reg [3];
  logic signed [15:0] x_val [XN];
  logic signed [15:0] item_in [3];

  eng_state_t state, state_next;
  layer_t     layer, layer_next;
  logic [NW-1:0]  n, n_next;
  logic [KW-1:0]  k, k_next;
  logic [WAW-1:0] waddr, waddr_next;
  logic [BAW-1:0] baddr, baddr_next;

  logic          advance;
  logic          issue;
  logic          pipe_empty;
  logic          last_k;
  logic          last_n;
  logic [KW-1:0] fanin_last;
  logic [NW-1:0] fanout_last;
  logic [AW-1:0] act_raddr;
  tag_t          issue_tag;

  logic                     s1v, s2v, s3v, s4v, s5v;
  tag_t                     s1_tag, s2_tag, s3_tag, s4_tag, s5_tag;
  logic signed [16:0]       s1_a;
  logic signed [15:0]       s1_w;
  logic signed [15:0]       s1_b;
  logic signed [32:0]       s2_prod;
  logic signed [31:0]       s2_b;
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  shifted;
  logic signed [15:0]       s4_q;
  logic [15:0]              offset;
  logic [15+DW:0]           scaled;
  logic [TW-1:0]            s5_idx;

  assign item_in[0] = head.x0;
  assign item_in[1] = head.x1;
  assign item_in[2] = head.x2;

  for (genvar g = 0; g < XN; g++) begin : g_x
    if (g < 3 && g < INPUT_COUNT) begin : g_live
      assign x_val[g] = x_reg[g];
    end else begin : g_zero
      assign x_val[g] = '0;
    end
  end

  assign advance    = !(result_valid && result_stall);
  assign pipe_empty = !(s1v || s2v || s3v || s4v || s5v);

  always_comb begin
    unique case (layer)
      LYR_ONE: begin
        fanin_last  = KW'(INPUT_COUNT - 1);
        fanout_last = NW'(HIDDEN1_COUNT - 1);
      end
      LYR_TWO: begin
        fanin_last  = KW'(HIDDEN1_COUNT - 1);
        fanout_last = NW'(HIDDEN2_COUNT - 1);
      end
      default: begin
        fanin_last  = KW'(HIDDEN2_COUNT - 1);
        fanout_last = NW'(OUTPUT_COUNT - 1);
      end
    endcase
  end

  assign last_k    = k == fanin_last;
  assign last_n    = n == fanout_last;
  assign act_raddr = AW'(((layer == LYR_THREE) ? HIDDEN1_COUNT : 0) + int'(k));

  assign issue_tag.layer = layer;
  assign issue_tag.first = k == '0;
  assign issue_tag.lastk = last_k;
  assign issue_tag.dest  = AW'(baddr);
  assign issue_tag.oidx  = 4'(n);
  assign issue_tag.olast = (layer == LYR_THREE) && last_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
    layer <= layer_next;
    n     <= n_next;
    k     <= k_next;
    waddr <= waddr_next;
    baddr <= baddr_next;
  end

  always_comb begin
    state_next = state;
    layer_next = layer;
    n_next     = n;
    k_next     = k;
    waddr_next = waddr;
    baddr_next = baddr;
    pop        = 1'b0;
    issue      = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_stat.empty) begin
          pop = 1'b1;
          if (head.cmd == CMD_EVAL) begin
            state_next = ST_RUN;
            layer_next = LYR_ONE;
            n_next     = '0;
            k_next     = '0;
            waddr_next = '0;
            baddr_next = '0;
          end
        end
      end
      ST_RUN: begin
        if (advance) begin
          issue      = 1'b1;
          waddr_next = waddr + 1'b1;
          if (last_k) begin
            k_next     = '0;
            baddr_next = baddr + 1'b1;
            if (last_n) begin
              n_next = '0;
              if (layer == LYR_THREE) begin
                state_next = ST_IDLE;
              end else begin
                layer_next = (layer == LYR_ONE) ? LYR_TWO : LYR_THREE;
                state_next = ST_DRAIN;
              end
            end else begin
              n_next = n + 1'b1;
            end
          end else begin
            k_next = k + 1'b1;
          end
        end
      end
      ST_DRAIN: begin
        // hold until the previous layer's activations are written back
        if (pipe_empty) begin
          state_next = ST_RUN;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // parameter loads and network inputs
  always_ff @(posedge clk) begin
    if (pop && head.cmd == CMD_WEIGHT) begin
      wmem[WAW'(32'(head.addr))] <= head.value;
    end
    if (pop && head.cmd == CMD_BIAS) begin
      bmem[BAW'(32'(head.addr))] <= head.value;
    end
    if (pop && head.cmd == CMD_EVAL) begin
      for (int i = 0; i < 3; i++) begin
        x_reg[i] <= item_in[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1v <= 1'b0;
      s2v <= 1'b0;
      s3v <= 1'b0;
      s4v <= 1'b0;
      s5v <= 1'b0;
    end else if (advance) begin
      s1v <= issue;
      s2v <= s1v;
      s3v <= s2v && s2_tag.lastk;
      s4v <= s3v;
      s5v <= s4v;
    end
  end

  always_comb begin
    shifted = (s3_tag.layer == LYR_ONE) ? (acc >>> 12) : (acc >>> 16);
    offset  = {~s4_q[15], s4_q[14:0]};
    scaled  = (16 + DW)'(offset) * (16 + DW)'(SIGMOID_TABLE_DEPTH);
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      // read: weight, bias and the previous layer's value
      w_read_blk: begin
        s1_w   <= wmem[waddr];
        s1_b   <= bmem[baddr];
        s1_tag <= issue_tag;
        if (layer == LYR_ONE) begin
          s1_a <= {x_val[k[XW-1:0]][15], x_val[k[XW-1:0]]};
        end else begin
          s1_a <= {1'b0, act[act_raddr]};
        end
      end
      // multiply, align bias
      s2_prod <= 33'(s1_a) * 33'(s1_w);
      s2_b    <= (s1_tag.layer == LYR_ONE) ? {{4{s1_b[15]}}, s1_b, 12'd0} : {s1_b, 16'd0};
      s2_tag  <= s1_tag;
      // accumulate
      if (s2v) begin
        acc <= (s2_tag.first ? ACC_W'(s2_b) : acc) + ACC_W'(s2_prod);
      end
      s3_tag <= s2_tag;
      // floor to Q4.12 and saturate
      if (shifted > SAT_HI) begin
        s4_q <= 16'sh7FFF;
      end else if (shifted < SAT_LO) begin
        s4_q <= -16'sh8000;
      end else begin
        s4_q <= shifted[15:0];
      end
      s4_tag <= s3_tag;
      // bucket of the sigmoid table
      s5_idx <= scaled[TW+15:16];
      s5_tag <= s4_tag;
      // write back hidden activations
      if (s5v && s5_tag.layer != LYR_THREE) begin
        act[s5_tag.dest] <= sig_rom[s5_idx];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance && s5v && s5_tag.layer == LYR_THREE) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s5v && s5_tag.layer == LYR_THREE) begin
      output_index <= s5_tag.oidx;
      output_score <= sig_rom[s5_idx];
      last         <= s5_tag.olast;
    end
  end

endmodule

FILE: design/mlp_forward_sigmoid_top.sv
// Load word: written into the weight or bias store when the idle engine pops it from the queue.
// Evaluate word: one multiply-accumulate per weight on a single shared MAC, a drain after each
// hidden layer until its activations are written back, and a 5-stage pipeline; the next evaluate
// is taken only after the previous one has issued its last output-layer weight.
// One evaluation runs at a time; a four-word queue keeps accepting until full, result_stall freezes the evaluation.
// Synchronous rst clears control and empties the queue; stores are garbage until loaded.
module mlp_forward_sigmoid_top import mlpfs_pkg::*; #(
  parameter int INPUT_COUNT         = 3,
  parameter int HIDDEN1_COUNT       = 5,
  parameter int HIDDEN2_COUNT       = 5,
  parameter int OUTPUT_COUNT        = 15,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic               command,
  input  logic [7:0]         param_index,
  input  logic signed [15:0] param_value,
  input  logic signed [15:0] input_first,
  input  logic signed [15:0] input_second,
  input  logic signed [15:0] input_third,
  output logic               result_valid,
  input  logic               result_stall,
  output logic [3:0]         output_index,
  output logic [15:0]        output_score,
  output logic               last
);

  localparam int WEIGHT_TOTAL = HIDDEN1_COUNT * INPUT_COUNT + HIDDEN2_COUNT * HIDDEN1_COUNT
                                + OUTPUT_COUNT * HIDDEN2_COUNT;
  localparam int BIAS_TOTAL   = HIDDEN1_COUNT + HIDDEN2_COUNT + OUTPUT_COUNT;

  queue_status_t q_stat;
  queue_word_t   push_word;
  queue_word_t   head;
  logic          push;
  logic          pop;

  mlpfs_front #(
    .WEIGHT_TOTAL(WEIGHT_TOTAL),
    .BIAS_TOTAL  (BIAS_TOTAL)
  ) u_front (
    .item_valid  (item_valid),
    .item_stall  (item_stall),
    .command     (command),
    .param_index (param_index),
    .param_value (param_value),
    .input_first (input_first),
    .input_second(input_second),
    .input_third (input_third),
    .q_stat      (q_stat),
    .push        (push),
    .word        (push_word)
  );

  mlpfs_queue u_queue (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .word  (push_word),
    .pop   (pop),
    .head  (head),
    .q_stat(q_stat)
  );

  mlpfs_engine #(
    .INPUT_COUNT        (INPUT_COUNT),
    .HIDDEN1_COUNT      (HIDDEN1_COUNT),
    .HIDDEN2_COUNT      (HIDDEN2_COUNT),
    .OUTPUT_COUNT       (OUTPUT_COUNT),
    .SIGMOID_TABLE_DEPTH(SIGMOID_TABLE_DEPTH)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_stat      (q_stat),
    .pop         (pop),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .output_index(output_index),
    .output_score(output_score),
    .last        (last)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_stat.full)
    else $error("word pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_stat.empty)
    else $error("word popped from an empty queue");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |-> (output_index == 4'(OUTPUT_COUNT - 1)))
    else $error("last flag on a score other than the final neuron");

  a_reset_clears_result: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");
`endif

endmodule
